### rtl/cbz_pkg.sv
package cbz_pkg;

	// One Q16.16 control or curve point.
	typedef struct packed {
		logic signed [31:0] y;
		logic signed [31:0] x;
	} pt_t;

	// Input request: one control point.
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               new_path;
	} in_item_t;

	// Output request: one curve sample.
	typedef struct packed {
		logic signed [31:0] curve_x;
		logic signed [31:0] curve_y;
		logic               run_last;
	} out_item_t;

	// A complete cubic segment, pts[0] is the start point.
	typedef struct packed {
		pt_t [3:0] pts;
	} seg_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### rtl/cbz_front.sv
module cbz_front
	import cbz_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      point_valid,
	output logic      point_stall,
	input  in_item_t  point,
	input  q_status_t q_status,
	output logic      push_valid,
	output seg_t      push_seg
);

	logic       anchor_q;
	logic [1:0] cnt_q;
	pt_t        p0_q;
	pt_t        p1_q;
	pt_t        p2_q;
	pt_t        pt_in;
	logic       accept;
	logic       restart;

	assign pt_in.x     = point.point_x;
	assign pt_in.y     = point.point_y;
	assign point_stall = q_status.full;
	assign accept      = point_valid && !q_status.full;
	assign restart     = point.new_path || !anchor_q;

	// Fourth point of a segment: hand the whole segment to the queue.
	assign push_valid  = accept && !restart && (cnt_q == 2'd2);
	assign push_seg.pts[0] = p0_q;
	assign push_seg.pts[1] = p1_q;
	assign push_seg.pts[2] = p2_q;
	assign push_seg.pts[3] = pt_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else if (accept) begin
			if (restart) begin
				anchor_q <= 1'b1;
				cnt_q    <= 2'd0;
			end else if (cnt_q == 2'd2) begin
				cnt_q <= 2'd0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// Point storage: no reset, guarded by anchor_q and cnt_q.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (restart || cnt_q == 2'd2) begin
				p0_q <= pt_in;
			end else begin
				case (cnt_q)
					2'd0:    p1_q <= pt_in;
					default: p2_q <= pt_in;
				endcase
			end
		end
	end

endmodule

### rtl/cbz_queue.sv
module cbz_queue
	import cbz_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  seg_t      push_seg,
	output q_status_t q_status,
	input  logic      pop,
	output logic      q_valid,
	output seg_t      q_seg
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);

	seg_t          ent_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign q_status.full  = (count_q == (AW+1)'(DEPTH));
	assign q_status.empty = (count_q == '0);
	assign q_valid        = !q_status.empty;
	assign q_seg          = ent_q[rd_ptr_q];
	assign do_push        = push_valid && !q_status.full;
	assign do_pop         = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= push_seg;
	end

endmodule

### rtl/cbz_back.sv
module cbz_back
	import cbz_pkg::*;
#(
	parameter int SEGMENT_STEPS    = 50,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  seg_t      q_seg,
	output logic      q_pop,
	output logic      sample_valid,
	input  logic      sample_stall,
	output out_item_t sample
);

	localparam int TW  = $clog2(SEGMENT_STEPS + 1);
	localparam int WW  = WEIGHT_FRAC_BITS + 1;
	localparam int PW  = 32 + WW + 1;
	localparam int SW2 = PW + 1;
	localparam int SW  = PW + 2;
	localparam longint unsigned S3 = longint'(SEGMENT_STEPS) * SEGMENT_STEPS * SEGMENT_STEPS;
	localparam logic signed [SW-1:0] HALF = SW'(longint'(1) << (WEIGHT_FRAC_BITS - 1));
	localparam logic [TW-1:0] T_LAST = TW'(SEGMENT_STEPS);

	// Rounded Bernstein weight table, one row per step.
	logic [WW-1:0] wtab [SEGMENT_STEPS+1][4];

	for (genvar t = 0; t <= SEGMENT_STEPS; t++) begin : g_t
		localparam longint unsigned A = longint'(t);
		localparam longint unsigned B = longint'(SEGMENT_STEPS - t);
		localparam longint unsigned N0 = B * B * B;
		localparam longint unsigned N1 = 3 * A * B * B;
		localparam longint unsigned N2 = 3 * A * A * B;
		localparam longint unsigned N3 = A * A * A;
		localparam longint unsigned W0 = ((N0 << WEIGHT_FRAC_BITS) + S3 / 2) / S3;
		localparam longint unsigned W1 = ((N1 << WEIGHT_FRAC_BITS) + S3 / 2) / S3;
		localparam longint unsigned W2 = ((N2 << WEIGHT_FRAC_BITS) + S3 / 2) / S3;
		localparam longint unsigned W3 = ((N3 << WEIGHT_FRAC_BITS) + S3 / 2) / S3;
		assign wtab[t][0] = WW'(W0);
		assign wtab[t][1] = WW'(W1);
		assign wtab[t][2] = WW'(W2);
		assign wtab[t][3] = WW'(W3);
	end

	function automatic logic [31:0] round_sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] sh;
		sh = v >>> WEIGHT_FRAC_BITS;
		if ((&sh[SW-1:31]) || !(|sh[SW-1:31])) begin
			return sh[31:0];
		end else begin
			return sh[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
	endfunction

	logic                 adv;
	logic                 busy_q;
	logic [TW-1:0]        t_q;
	seg_t                 seg_q;
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic                 last_s1, last_s2, last_s3, last_s4;
	logic [WW-1:0]        w_s1 [4];
	seg_t                 seg_s1;
	logic signed [PW-1:0] px_s2 [4];
	logic signed [PW-1:0] py_s2 [4];
	logic signed [SW2-1:0] sx_s3 [2];
	logic signed [SW2-1:0] sy_s3 [2];
	logic signed [SW-1:0] rx_s4;
	logic signed [SW-1:0] ry_s4;
	logic                 out_valid_q;
	out_item_t            out_q;

	// Whole pipeline moves together unless the output is held.
	assign adv          = !(out_valid_q && sample_stall);
	assign q_pop        = adv && q_valid && (!busy_q || t_q == T_LAST);
	assign sample_valid = out_valid_q;
	assign sample       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			t_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (busy_q && t_q != T_LAST) begin
				t_q <= t_q + 1'b1;
			end else if (q_valid) begin
				t_q    <= '0;
				busy_q <= 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
			v_s1        <= busy_q;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_pop) seg_q <= q_seg;
			// look up weights for this step
			for (int k = 0; k < 4; k++) w_s1[k] <= wtab[t_q][k];
			seg_s1  <= seg_q;
			last_s1 <= (t_q == T_LAST);
			// one multiplier per lane and axis
			for (int k = 0; k < 4; k++) begin
				px_s2[k] <= seg_s1.pts[k].x * $signed({1'b0, w_s1[k]});
				py_s2[k] <= seg_s1.pts[k].y * $signed({1'b0, w_s1[k]});
			end
			last_s2 <= last_s1;
			sx_s3[0] <= {px_s2[0][PW-1], px_s2[0]} + {px_s2[1][PW-1], px_s2[1]};
			sx_s3[1] <= {px_s2[2][PW-1], px_s2[2]} + {px_s2[3][PW-1], px_s2[3]};
			sy_s3[0] <= {py_s2[0][PW-1], py_s2[0]} + {py_s2[1][PW-1], py_s2[1]};
			sy_s3[1] <= {py_s2[2][PW-1], py_s2[2]} + {py_s2[3][PW-1], py_s2[3]};
			last_s3  <= last_s2;
			rx_s4 <= {sx_s3[0][SW2-1], sx_s3[0]} + {sx_s3[1][SW2-1], sx_s3[1]} + HALF;
			ry_s4 <= {sy_s3[0][SW2-1], sy_s3[0]} + {sy_s3[1][SW2-1], sy_s3[1]} + HALF;
			last_s4 <= last_s3;
			out_q.curve_x  <= round_sat(rx_s4);
			out_q.curve_y  <= round_sat(ry_s4);
			out_q.run_last <= last_s4;
		end
	end

endmodule

### rtl/cubic_bezier_segment_sampler.sv
// Cubic Bezier segment sampler.
// The point channel (point_valid / point_stall / point) takes one Q16.16
// control point per request. Segments share endpoints: points 0..3, then
// 3..6, and so on; new_path starts a fresh list and drops any partial one.
// Each completed segment yields SEGMENT_STEPS+1 requests on the sample
// channel (sample_valid / sample_stall / sample), one per cycle while the
// receiver does not stall, the last one flagged with run_last.
// The first sample of a segment passes through the queue, segment load,
// weight lookup, multiply, two adder stages and output register.
// The step counter driving the weight table walks each segment, and the
// back end can start the next queued segment right after the last step
// of the previous one.
// The front keeps accepting points while the back works; a two-segment queue
// sits between them and point_stall rises only when that queue is full.
// Reset clears the path state, the queue and all valid bits; no sample is
// pending afterwards. When the receiver stalls, the sample holds and the
// whole back pipeline freezes, so nothing is lost or repeated.
module cubic_bezier_segment_sampler
	import cbz_pkg::*;
#(
	parameter int SEGMENT_STEPS    = 50,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      point_valid,
	output logic      point_stall,
	input  in_item_t  point,
	output logic      sample_valid,
	input  logic      sample_stall,
	output out_item_t sample
);

	q_status_t q_status;
	logic      push_valid;
	seg_t      push_seg;
	logic      q_valid;
	seg_t      q_seg;
	logic      q_pop;

	// Front: collect points, classify, push complete segments.
	cbz_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.q_status    (q_status),
		.push_valid  (push_valid),
		.push_seg    (push_seg)
	);

	// Decoupling queue between front and back.
	cbz_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_seg   (push_seg),
		.q_status   (q_status),
		.pop        (q_pop),
		.q_valid    (q_valid),
		.q_seg      (q_seg)
	);

	// Back: step through the segment and evaluate the weighted sums.
	cbz_back #(
		.SEGMENT_STEPS    (SEGMENT_STEPS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_seg        (q_seg),
		.q_pop        (q_pop),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample)
	);

endmodule

### test/bezier_sample_checker.sv
module bezier_sample_checker
	import cbz_pkg::*;
#(
	parameter int SEGMENT_STEPS    = 50,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      point_valid,
	input  logic      point_stall,
	input  in_item_t  point,
	input  logic      sample_valid,
	input  logic      sample_stall,
	input  out_item_t sample,
	output int        errors,
	output int        pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SAT_MAX = 64'sd2147483647;
	localparam longint SAT_MIN = -64'sd2147483648;

	pt_t       ctrl_pts [4];
	logic      anchor_held;
	int        held_count;
	out_item_t expected_samples [$];

	// Rounded Bernstein weight k at step t, exact integer arithmetic.
	function automatic longint curve_weight(input int k, input int t);
		longint unsigned num;
		longint unsigned den;
		longint unsigned a;
		longint unsigned b;
		num = (k == 0 || k == 3) ? 64'd1 : 64'd3;
		a   = longint'(t);
		b   = longint'(SEGMENT_STEPS - t);
		den = longint'(SEGMENT_STEPS) * SEGMENT_STEPS * SEGMENT_STEPS;
		for (int i = 0; i < k; i++)
			num = num * a;
		for (int i = k; i < 3; i++)
			num = num * b;
		num = num << WEIGHT_FRAC_BITS;
		return longint'((num + den / 2) / den);
	endfunction

	// Round to nearest (ties up) and clamp to the signed 32-bit range.
	function automatic logic signed [31:0] round_clamp(input longint acc);
		longint r;
		r = (acc + (longint'(1) <<< (WEIGHT_FRAC_BITS - 1))) >>> WEIGHT_FRAC_BITS;
		if (r > SAT_MAX)
			r = SAT_MAX;
		if (r < SAT_MIN)
			r = SAT_MIN;
		return r[31:0];
	endfunction

	task automatic queue_segment_samples();
		longint    sx;
		longint    sy;
		longint    w;
		out_item_t s;
		for (int t = 0; t <= SEGMENT_STEPS; t++) begin
			sx = 0;
			sy = 0;
			for (int k = 0; k < 4; k++) begin
				w  = curve_weight(k, t);
				sx = sx + w * longint'(ctrl_pts[k].x);
				sy = sy + w * longint'(ctrl_pts[k].y);
			end
			s.curve_x  = round_clamp(sx);
			s.curve_y  = round_clamp(sy);
			s.run_last = (t == SEGMENT_STEPS);
			expected_samples = {expected_samples, s};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_s;
		pt_t       p;
		if (!arst_n) begin
			anchor_held = 1'b0;
			held_count  = 0;
			expected_samples.delete();
		end else begin
			if (sample_valid && !sample_stall) begin
				if (expected_samples.size() == 0) begin
					$error("sample with nothing expected: x %0d y %0d last %0b",
						sample.curve_x, sample.curve_y, sample.run_last);
					errors++;
				end else begin
					exp_s = expected_samples.pop_front();
					if (sample.curve_x !== exp_s.curve_x) begin
						$error("curve_x: expected %0d, got %0d", exp_s.curve_x, sample.curve_x);
						errors++;
					end
					if (sample.curve_y !== exp_s.curve_y) begin
						$error("curve_y: expected %0d, got %0d", exp_s.curve_y, sample.curve_y);
						errors++;
					end
					if (sample.run_last !== exp_s.run_last) begin
						$error("run_last: expected %0b, got %0b", exp_s.run_last,
							sample.run_last);
						errors++;
					end
				end
			end
			if (point_valid && !point_stall) begin
				p.x = point.point_x;
				p.y = point.point_y;
				if (point.new_path || !anchor_held) begin
					ctrl_pts[0] = p;
					anchor_held = 1'b1;
					held_count  = 0;
				end else if (held_count < 2) begin
					ctrl_pts[1 + held_count] = p;
					held_count++;
				end else begin
					ctrl_pts[3] = p;
					queue_segment_samples();
					ctrl_pts[0] = p;
					held_count  = 0;
				end
			end
		end
		pending = expected_samples.size();
	end

endmodule

### test/testbench.sv
module testbench
	import cbz_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS       = 50;
	localparam int WFRAC       = 16;
	localparam int RANDOM_PTS  = 185;
	// Longest quiet stretch: a sender gap plus pipeline latency, or a run of
	// receiver stalls; this is many times either.
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_TAIL  = 40;

	localparam logic signed [31:0] C_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] C_MIN = 32'sh80000000;

	logic      clk;
	logic      arst_n;
	logic      point_valid;
	logic      point_stall;
	in_item_t  point;
	logic      sample_valid;
	logic      sample_stall;
	out_item_t sample;

	int errors;
	int pending;
	int idle_cycles;
	int burst_left;
	int sent;
	int stall_mode;
	int stall_hold;
	int stall_phase;

	cubic_bezier_segment_sampler #(
		.SEGMENT_STEPS   (STEPS),
		.WEIGHT_FRAC_BITS(WFRAC)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample)
	);

	bezier_sample_checker #(
		.SEGMENT_STEPS   (STEPS),
		.WEIGHT_FRAC_BITS(WFRAC)
	) sample_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.errors      (errors),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver back-pressure: switch every so often between no stall, light
	// random stall, heavy random stall and a fixed periodic pattern.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_hold = $urandom_range(20, 200);
		end else begin
			stall_hold--;
		end
		stall_phase = (stall_phase == 4) ? 0 : stall_phase + 1;
		case (stall_mode)
			0: begin
				sample_stall <= 1'b0;
			end
			1: begin
				sample_stall <= ($urandom_range(0, 99) < 30);
			end
			2: begin
				sample_stall <= ($urandom_range(0, 7) != 0);
			end
			default: begin
				sample_stall <= (stall_phase < 2);
			end
		endcase
	end

	// Watchdog: end the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (point_valid && !point_stall) || (sample_valid && !sample_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic in_item_t mk_point(input logic signed [31:0] x,
		input logic signed [31:0] y, input logic np);
		in_item_t r;
		r.point_x  = x;
		r.point_y  = y;
		r.new_path = np;
		return r;
	endfunction

	// Mix of full-range, small and extreme coordinates.
	function automatic logic signed [31:0] make_coord();
		logic signed [31:0] v;
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				v = $urandom;
			end
			3, 4: begin
				v = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: v = C_MAX;
					1: v = C_MIN;
					2: v = 32'sd0;
					default: v = -32'sd1;
				endcase
			end
		endcase
		return v;
	endfunction

	// Present one request and hold it until accepted. The sender works in
	// bursts: when a burst runs out, drop valid for a random gap first.
	task automatic send_point(input in_item_t req);
		if (burst_left == 0) begin
			point_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			// Some long bursts give stretches with no sender idling at all.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		point       <= req;
		point_valid <= 1'b1;
		do
			@(posedge clk);
		while (point_stall);
		burst_left--;
		sent++;
	endtask

	task automatic send_random(input logic np);
		send_point(mk_point(make_coord(), make_coord(), np));
	endtask

	initial begin
		int segs;
		// Drive reset and the point channel to known values at time zero.
		arst_n      = 1'b0;
		point_valid = 1'b0;
		point       = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part.
		// First point without new_path still anchors a path; then an all
		// maximum segment, where rounded weights summing past one saturate.
		send_point(mk_point(32'sd0, 32'sd0, 1'b0));
		send_point(mk_point(C_MAX, C_MAX, 1'b0));
		send_point(mk_point(C_MAX, C_MAX, 1'b0));
		send_point(mk_point(C_MAX, C_MAX, 1'b0));
		// Lone anchor immediately replaced by a restart.
		send_point(mk_point(32'sd1, -32'sd1, 1'b1));
		// All minimum segment: saturation toward the negative bound.
		send_point(mk_point(C_MIN, C_MIN, 1'b1));
		send_point(mk_point(C_MIN, C_MIN, 1'b0));
		send_point(mk_point(C_MIN, C_MIN, 1'b0));
		send_point(mk_point(C_MIN, C_MIN, 1'b0));
		// Opposite extremes per axis.
		send_point(mk_point(C_MAX, C_MIN, 1'b1));
		send_point(mk_point(C_MIN, C_MAX, 1'b0));
		send_point(mk_point(32'sd0, -32'sd1, 1'b0));
		send_point(mk_point(-32'sd1, 32'sd0, 1'b0));
		// Chained segment sharing the previous endpoint.
		send_point(mk_point(32'sh0001_0000, 32'sh0002_8000, 1'b0));
		send_point(mk_point(-32'sh0003_0000, 32'sh0000_8000, 1'b0));
		send_point(mk_point(32'sh0010_0000, -32'sh0010_0000, 1'b0));
		// Restart mid-segment: the two collected points are dropped.
		send_point(mk_point(32'sh0000_1234, 32'sh0000_5678, 1'b0));
		send_point(mk_point(32'sh0100_0000, 32'sh0200_0000, 1'b0));
		send_point(mk_point(32'sh0005_0000, 32'sh0006_0000, 1'b1));
		send_point(mk_point(32'sh7FFF_0000, -32'sh7FFF_0000, 1'b0));
		send_point(mk_point(-32'sh0000_0001, 32'sh0000_0001, 1'b0));
		send_point(mk_point(32'sh0000_8000, 32'sh0000_8000, 1'b0));

		// Random part: mostly well-formed paths with random content, plus
		// continuations without a restart, broken tails and pure noise.
		sent = 0;
		while (sent < RANDOM_PTS) begin
			if ($urandom_range(0, 19) == 0) begin
				repeat (4) send_random(1'($urandom_range(0, 1)));
			end else begin
				send_random($urandom_range(0, 9) != 0);
				segs = $urandom_range(1, 3);
				repeat (3 * segs) send_random(1'b0);
				// Trailing points that never complete a segment.
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 2)) send_random(1'b0);
			end
		end
		// Leave a short incomplete tail at the very end too.
		send_random(1'b1);
		send_random(1'b0);
		point_valid <= 1'b0;

		// Drain: wait for every expected sample, then a few more cycles so
		// that any stray sample still in flight gets caught.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

### cubic_bezier_segment_sampler.f
rtl/cbz_pkg.sv
rtl/cbz_front.sv
rtl/cbz_queue.sv
rtl/cbz_back.sv
rtl/cubic_bezier_segment_sampler.sv
test/bezier_sample_checker.sv
test/testbench.sv
